@@ rtl/acrp_pkg.sv @@
// Package for the attack command record parser: parse phases, record kinds,
// error codes, the result record type and register defaults. No dependencies.
`default_nettype none

package acrp_pkg;

  // register defaults and register map
  localparam logic [7:0] AttackKindsReset = 8'd11;
  localparam logic [7:0] FlagKindsReset   = 8'd26;
  localparam int unsigned AddrWidth       = 3;
  localparam logic        RegAttackKinds  = 1'b0;
  localparam logic        RegFlagKinds    = 1'b1;

  // result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // parse phases, one-hot
  typedef enum logic [8:0] {
    PH_DUR      = 9'b000000001,
    PH_KIND     = 9'b000000010,
    PH_COUNT    = 9'b000000100,
    PH_TARGET   = 9'b000001000,
    PH_FCOUNT   = 9'b000010000,
    PH_KEY      = 9'b000100000,
    PH_LEN      = 9'b001000000,
    PH_DATA     = 9'b010000000,
    PH_FINISHED = 9'b100000000
  } phase_e;

  typedef enum logic [2:0] {
    REC_DUR    = 3'd0,
    REC_KIND   = 3'd1,
    REC_TARGET = 3'd2,
    REC_OPT    = 3'd3,
    REC_VAL    = 3'd4,
    REC_DONE   = 3'd5,
    REC_ERR    = 3'd6
  } rec_kind_e;

  typedef enum logic [3:0] {
    ERR_SHORT     = 4'd0,
    ERR_NO_KIND   = 4'd1,
    ERR_NO_COUNT  = 4'd2,
    ERR_ZERO_TGT  = 4'd3,
    ERR_TARGETS   = 4'd4,
    ERR_FCOUNT    = 4'd5,
    ERR_KEY       = 4'd6,
    ERR_LEN       = 4'd7,
    ERR_DATA      = 4'd8,
    ERR_BAD_KIND  = 4'd9
  } err_code_e;

  typedef struct packed {
    rec_kind_e   kind;
    logic [31:0] value;
    logic [7:0]  extra;
    logic        known;
    err_code_e   err;
    logic        fin;
  } rec_t;

  // up to two records produced by one beat
  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } rec_pair_t;

  function automatic rec_t make_rec(rec_kind_e kind, logic [31:0] value, logic [7:0] extra,
                                    logic known, err_code_e err, logic fin);
    rec_t r;
    r.kind  = kind;
    r.value = value;
    r.extra = extra;
    r.known = known;
    r.err   = err;
    r.fin   = fin;
    return r;
  endfunction

  // append a record, dropping anything past the second
  function automatic rec_pair_t push_rec(rec_pair_t p, rec_t r);
    rec_pair_t q;
    q = p;
    if (p.n == 2'd0) begin
      q.r0 = r;
      q.n  = 2'd1;
    end else if (p.n == 2'd1) begin
      q.r1 = r;
      q.n  = 2'd2;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

@@ rtl/attack_command_record_parser_unit.sv @@
// Top level of the attack command record parser: byte stream in, result
// records out, APB registers for attack_kinds and flag_kinds. Uses acrp_pkg.
`default_nettype none

// One byte is taken per beat and parsed combinationally: the phase, counters
// and accumulator update at the accept edge and the records that byte causes
// (at most two) go into a four-entry result queue. Input tready is high while
// the queue has room for two records, so with the output side taking records
// the block sustains one byte per cycle; a byte that causes two records fills
// the queue faster. Records leave it at one per cycle while the output is ready.
// A beat with tlast set ends the buffer and returns the parser to its start.
module attack_command_record_parser_unit
  import acrp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // byte stream
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // data_byte
  input  wire logic                 s_axis_tuser_i,   // has_byte
  input  wire logic                 s_axis_tlast_i,   // last_byte
  // result records
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // value[31:0], extra[39:32], known_key[40], error_code[44:41], zero[47:45]
  output      logic [47:0]          m_axis_tdata_o,
  output      logic [2:0]           m_axis_tuser_o,   // record_kind
  output      logic                 m_axis_tlast_o,   // final_record
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);

  // configuration registers
  logic [7:0] attack_kinds_q, flag_kinds_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_kinds_q <= AttackKindsReset;
      flag_kinds_q   <= FlagKindsReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegAttackKinds) begin
        attack_kinds_q <= pwdata[7:0];
      end else begin
        flag_kinds_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegAttackKinds) begin
      prdata = {24'd0, attack_kinds_q};
    end else begin
      prdata = {24'd0, flag_kinds_q};
    end
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  tgt_left_q, tgt_left_d;
  logic [7:0]  opt_left_q, opt_left_d;
  logic [7:0]  val_left_q, val_left_d;
  logic [7:0]  key_q, key_d;
  rec_pair_t   recs;

  logic in_acc;
  logic [7:0] b;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign b      = s_axis_tdata_i;

  // one-byte parse step
  always_comb begin
    rec_pair_t p;
    logic      close;
    phase_d    = phase_q;
    bidx_d     = bidx_q;
    acc_d      = acc_q;
    kind_d     = kind_q;
    tgt_left_d = tgt_left_q;
    opt_left_d = opt_left_q;
    val_left_d = val_left_q;
    key_d      = key_q;
    p          = '0;
    close      = 1'b0;

    if (s_axis_tuser_i) begin
      case (phase_q)
        PH_DUR: begin
          acc_d  = {acc_q[23:0], b};
          bidx_d = bidx_q + 3'd1;
          if (bidx_d >= 3'd4) begin
            p = push_rec(p, make_rec(REC_DUR, acc_d, 8'd0, 1'b0, ERR_SHORT, 1'b0));
            bidx_d  = 3'd0;
            acc_d   = 32'd0;
            phase_d = PH_KIND;
          end
        end
        PH_KIND: begin
          kind_d  = b;
          p = push_rec(p, make_rec(REC_KIND, {24'd0, b}, 8'd0, 1'b0, ERR_SHORT, 1'b0));
          phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          if (b == 8'd0) begin
            p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_ZERO_TGT, 1'b1));
            phase_d = PH_FINISHED;
          end else begin
            tgt_left_d = b;
            bidx_d     = 3'd0;
            acc_d      = 32'd0;
            phase_d    = PH_TARGET;
          end
        end
        PH_TARGET: begin
          if (bidx_q < 3'd4) begin
            acc_d  = {acc_q[23:0], b};
            bidx_d = bidx_q + 3'd1;
          end else begin
            p = push_rec(p, make_rec(REC_TARGET, acc_q, b, 1'b0, ERR_SHORT, 1'b0));
            bidx_d     = 3'd0;
            acc_d      = 32'd0;
            tgt_left_d = tgt_left_q - 8'd1;
            if (tgt_left_d == 8'd0) begin
              phase_d = PH_FCOUNT;
            end
          end
        end
        PH_FCOUNT: begin
          opt_left_d = b;
          close      = 1'b1;
        end
        PH_KEY: begin
          key_d   = b;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          p = push_rec(p, make_rec(REC_OPT, {24'd0, key_q}, b, key_q < flag_kinds_q,
                                   ERR_SHORT, 1'b0));
          opt_left_d = opt_left_q - 8'd1;
          val_left_d = b;
          if (b == 8'd0) begin
            close = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          p = push_rec(p, make_rec(REC_VAL, {24'd0, b}, 8'd0, 1'b0, ERR_SHORT, 1'b0));
          val_left_d = val_left_q - 8'd1;
          if (val_left_d == 8'd0) begin
            close = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // end of an option or of the option count
      if (close) begin
        if (opt_left_d != 8'd0) begin
          phase_d = PH_KEY;
        end else if (kind_q >= attack_kinds_q) begin
          p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_BAD_KIND, 1'b1));
          phase_d = PH_FINISHED;
        end else begin
          p = push_rec(p, make_rec(REC_DONE, 32'd0, 8'd0, 1'b0, ERR_SHORT, 1'b1));
          phase_d = PH_FINISHED;
        end
      end
    end

    // end of buffer: report what is missing, then start over
    if (s_axis_tlast_i) begin
      case (phase_d)
        PH_DUR:    p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_SHORT, 1'b1));
        PH_KIND:   p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_NO_KIND, 1'b1));
        PH_COUNT:  p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_NO_COUNT, 1'b1));
        PH_TARGET: p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_TARGETS, 1'b1));
        PH_FCOUNT: p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_FCOUNT, 1'b1));
        PH_KEY:    p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_KEY, 1'b1));
        PH_LEN:    p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_LEN, 1'b1));
        PH_DATA:   p = push_rec(p, make_rec(REC_ERR, 32'd0, 8'd0, 1'b0, ERR_DATA, 1'b1));
        default: begin
        end
      endcase
      phase_d    = PH_DUR;
      bidx_d     = 3'd0;
      acc_d      = 32'd0;
      kind_d     = 8'd0;
      tgt_left_d = 8'd0;
      opt_left_d = 8'd0;
      val_left_d = 8'd0;
      key_d      = 8'd0;
    end
    recs = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DUR;
      bidx_q     <= 3'd0;
      acc_q      <= 32'd0;
      kind_q     <= 8'd0;
      tgt_left_q <= 8'd0;
      opt_left_q <= 8'd0;
      val_left_q <= 8'd0;
      key_q      <= 8'd0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      bidx_q     <= bidx_d;
      acc_q      <= acc_d;
      kind_q     <= kind_d;
      tgt_left_q <= tgt_left_d;
      opt_left_q <= opt_left_d;
      val_left_q <= val_left_d;
      key_q      <= key_d;
    end
  end

  // result queue
  rec_t                 queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 pop;
  logic [1:0]           n_push;
  rec_t                 head;

  assign n_push          = in_acc ? recs.n : 2'd0;
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = count_q <= QueueCntW'(QueueDepth - 2);
  assign m_axis_tvalid_o = count_q != '0;
  assign head            = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= recs.r0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= recs.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_q + QueueCntW'(n_push) - QueueCntW'(pop);
    end
  end

  // output beat
  assign m_axis_tdata_o = {3'd0, head.err, head.known, head.extra, head.value};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.fin;

  // checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("result queue over its depth");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (phase_q == PH_DUR && bidx_q == 3'd0))
    else $error("parser did not restart after end of buffer");

  a_finished_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FINISHED && !(in_acc && s_axis_tlast_i)) |=> phase_q == PH_FINISHED)
    else $error("parser left finished phase without end of buffer");

  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tuser_o == REC_DONE || m_axis_tuser_o == REC_ERR))
    else $error("final flag on a record that is not done or error");

endmodule

`default_nettype wire

@@ verif/attack_command_record_parser_unit_test.sv @@
// Testbench for attack_command_record_parser_unit: streams command buffers in,
// predicts every result record and checks each one as it leaves the block.
// Depends on rtl/acrp_pkg.sv and rtl/attack_command_record_parser_unit.sv.
`timescale 1ns / 1ps

module attack_command_record_parser_unit_test;
  import acrp_pkg::*;

  // tracks the parse of the byte stream and holds the records still due
  class parse_tracker;
    phase_e      ph;
    logic [2:0]  byte_idx;
    logic [31:0] acc;
    logic [7:0]  kind_code;
    logic [7:0]  tgt_left;
    logic [7:0]  opt_left;
    logic [7:0]  val_left;
    logic [7:0]  cur_key;
    logic [7:0]  attack_kinds;
    logic [7:0]  flag_kinds;
    rec_t        due_records[$];
    int          errors;

    function new();
      attack_kinds = AttackKindsReset;
      flag_kinds   = FlagKindsReset;
      errors       = 0;
      restart();
    endfunction

    function void restart();
      ph        = PH_DUR;
      byte_idx  = '0;
      acc       = '0;
      kind_code = '0;
      tgt_left  = '0;
      opt_left  = '0;
      val_left  = '0;
      cur_key   = '0;
    endfunction

    function void push(rec_kind_e k, logic [31:0] v, logic [7:0] x, logic kn, err_code_e e,
                       logic f);
      rec_t r;
      r.kind  = k;
      r.value = v;
      r.extra = x;
      r.known = kn;
      r.err   = e;
      r.fin   = f;
      due_records.push_back(r);
    endfunction

    function void end_with_error(err_code_e e);
      push(REC_ERR, 32'd0, 8'd0, 1'b0, e, 1'b1);
      ph = PH_FINISHED;
    endfunction

    // one option finished: next key, or the end of the record
    function void option_done();
      if (opt_left == 8'd0) begin
        if (kind_code >= attack_kinds) begin
          end_with_error(ERR_BAD_KIND);
        end else begin
          push(REC_DONE, 32'd0, 8'd0, 1'b0, ERR_SHORT, 1'b1);
          ph = PH_FINISHED;
        end
      end else begin
        ph = PH_KEY;
      end
    endfunction

    // predict the records caused by one accepted input beat
    function void note_byte_beat(logic [7:0] b, logic has, logic last);
      if (has) begin
        case (ph)
          PH_DUR: begin
            acc = {acc[23:0], b};
            byte_idx++;
            if (byte_idx >= 3'd4) begin
              push(REC_DUR, acc, 8'd0, 1'b0, ERR_SHORT, 1'b0);
              byte_idx = '0;
              acc      = '0;
              ph       = PH_KIND;
            end
          end
          PH_KIND: begin
            kind_code = b;
            push(REC_KIND, {24'd0, b}, 8'd0, 1'b0, ERR_SHORT, 1'b0);
            ph = PH_COUNT;
          end
          PH_COUNT: begin
            if (b == 8'd0) begin
              end_with_error(ERR_ZERO_TGT);
            end else begin
              tgt_left = b;
              byte_idx = '0;
              acc      = '0;
              ph       = PH_TARGET;
            end
          end
          PH_TARGET: begin
            if (byte_idx < 3'd4) begin
              acc = {acc[23:0], b};
              byte_idx++;
            end else begin
              // fifth byte is the netmask
              push(REC_TARGET, acc, b, 1'b0, ERR_SHORT, 1'b0);
              byte_idx = '0;
              acc      = '0;
              tgt_left--;
              if (tgt_left == 8'd0) ph = PH_FCOUNT;
            end
          end
          PH_FCOUNT: begin
            opt_left = b;
            option_done();
          end
          PH_KEY: begin
            cur_key = b;
            ph      = PH_LEN;
          end
          PH_LEN: begin
            push(REC_OPT, {24'd0, cur_key}, b, cur_key < flag_kinds, ERR_SHORT, 1'b0);
            opt_left--;
            val_left = b;
            if (b == 8'd0) option_done();
            else ph = PH_DATA;
          end
          PH_DATA: begin
            push(REC_VAL, {24'd0, b}, 8'd0, 1'b0, ERR_SHORT, 1'b0);
            val_left--;
            if (val_left == 8'd0) option_done();
          end
          default: ;
        endcase
      end
      // end of buffer: report what is missing, then start over
      if (last) begin
        case (ph)
          PH_DUR:    end_with_error(ERR_SHORT);
          PH_KIND:   end_with_error(ERR_NO_KIND);
          PH_COUNT:  end_with_error(ERR_NO_COUNT);
          PH_TARGET: end_with_error(ERR_TARGETS);
          PH_FCOUNT: end_with_error(ERR_FCOUNT);
          PH_KEY:    end_with_error(ERR_KEY);
          PH_LEN:    end_with_error(ERR_LEN);
          PH_DATA:   end_with_error(ERR_DATA);
          default: ;
        endcase
        restart();
      end
    endfunction

    // compare one accepted output beat with the oldest record due
    function void check_record(logic [47:0] data, logic [2:0] user, logic last);
      rec_t e;
      if (due_records.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: record with none due: kind %0d data %h last %b",
                   $realtime, user, data, last);
        return;
      end
      e = due_records.pop_front();
      if (user !== e.kind || data[31:0] !== e.value || data[39:32] !== e.extra ||
          data[40] !== e.known || data[44:41] !== e.err || data[47:45] !== 3'd0 ||
          last !== e.fin) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected kind %0d value %h extra %h known %b err %0d fin %b",
                   $realtime, e.kind, e.value, e.extra, e.known, e.err, e.fin,
                   "\n          actual kind %0d value %h extra %h known %b err %0d fin %b pad %b",
                   user, data[31:0], data[39:32], data[40], data[44:41], last, data[47:45]);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;   // data_byte
  logic                 s_tuser = 1'b0;   // has_byte
  logic                 s_tlast = 1'b0;   // last_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // value[31:0], extra[39:32], known_key[40], error_code[44:41], zero[47:45]
  logic [47:0]          m_tdata;
  logic [2:0]           m_tuser;          // record_kind
  logic                 m_tlast;          // final_record
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = 32'd0;
  logic [31:0]          prdata;
  logic                 pready;

  parse_tracker tracker = new();
  bit           no_idle = 1'b0;
  int unsigned  beats_sent = 0;

  attack_command_record_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // output side: check every accepted record, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) tracker.check_record(m_tdata, m_tuser, m_tlast);
    m_tready <= no_idle || ($urandom_range(0, 99) >= 12);
  end

  // one input beat, with a random gap before it
  task automatic send_beat(logic [7:0] b, logic has, logic last);
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    tracker.note_byte_beat(b, has, last);
    if (has) beats_sent++;
  endtask

  // send the first nsend bytes, ending the buffer on the last one or on an empty beat
  task automatic send_buffer(ref logic [7:0] bytes[$], input int unsigned nsend,
                             input bit empty_end);
    for (int unsigned i = 0; i < nsend; i++) begin
      if ($urandom_range(0, 99) < 4) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(bytes[i], 1'b1, (i == nsend - 1) && !empty_end);
    end
    if (empty_end) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // register write: setup cycle, then access cycle
  task automatic reg_write(logic [AddrWidth-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for every due record, then let the result queue settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.due_records.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [7:0] ak, logic [7:0] fk);
    drain();
    reg_write(AddrWidth'(4 * RegAttackKinds), {24'd0, ak});
    // random upper bits, only the low byte is kept
    reg_write(AddrWidth'(4 * RegFlagKinds), {24'($urandom), fk});
    tracker.attack_kinds = ak;
    tracker.flag_kinds   = fk;
  endtask

  // a well-formed record with random content, sized mostly small
  task automatic build_record(ref logic [7:0] q[$]);
    logic [31:0] dur;
    int unsigned ntgt;
    int unsigned nopt;
    int unsigned vlen;
    int unsigned r;
    q.delete();
    dur = $urandom;
    for (int i = 3; i >= 0; i--) q.push_back(dur[8*i +: 8]);
    if ($urandom_range(0, 99) < 70) q.push_back(8'($urandom_range(0, tracker.attack_kinds - 1)));
    else q.push_back(8'($urandom));
    r = $urandom_range(0, 99);
    ntgt = (r < 6) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(1, 255);
    q.push_back(8'(ntgt));
    if (ntgt == 0) return;
    for (int unsigned t = 0; t < ntgt && q.size() < 400; t++)
      repeat (5) q.push_back(8'($urandom));
    nopt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    q.push_back(8'(nopt));
    for (int unsigned o = 0; o < nopt && q.size() < 400; o++) begin
      if ($urandom_range(0, 1) == 1) q.push_back(8'($urandom_range(0, tracker.flag_kinds - 1)));
      else q.push_back(8'($urandom));
      r = $urandom_range(0, 99);
      vlen = (r < 25) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(0, 255);
      q.push_back(8'(vlen));
      repeat (vlen) q.push_back(8'($urandom));
    end
  endtask

  // one random buffer: mostly records, some cut short, some plain noise
  task automatic random_buffer();
    logic [7:0]  q[$];
    int unsigned nsend;
    bit          full;
    bit          empty_end;
    if ($urandom_range(0, 99) < 8) begin
      q.delete();
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
    end else begin
      build_record(q);
    end
    full  = (q.size() <= 300) && ($urandom_range(0, 99) < 60);
    nsend = full ? q.size() : $urandom_range(0, q.size() - 1);
    if (full && $urandom_range(0, 2) == 0) begin
      // trailing bytes after completion are ignored
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
      nsend = q.size();
    end
    empty_end = (nsend == 0) || ($urandom_range(0, 3) == 0);
    send_buffer(q, nsend, empty_end);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0]  q[$];
    int unsigned phase_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full record with reset limits: highest valid kind, known and unknown key,
    // zero-length option, done on the final byte
    q = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'd10, 8'd1,
          8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF,
          8'd2, 8'd25, 8'd0, 8'd26, 8'd1, 8'hFF};
    send_buffer(q, q.size(), 1'b0);
    // zero target count, then ignored bytes up to the end of buffer
    q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA};
    send_buffer(q, q.size(), 1'b0);
    // empty beat alone, then empty end of buffer
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);

    // random buffers under several limit settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_limits(8'd1, 8'd1);
        1: set_limits(8'd255, 8'd255);
        2: set_limits(8'd1, 8'd255);
        3: set_limits(8'd255, 8'd1);
        default: set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      endcase
      no_idle = (p == 2);
      phase_start = beats_sent;
      while (beats_sent - phase_start < 330) random_buffer();
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.due_records.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
